// ----- sv/gsm7_page_packer_defines.svh -----
// Assertion macros shared by the checker files of the GSM 7-bit page packer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GSM7_PAGE_PACKER_DEFINES_SVH
`define GSM7_PAGE_PACKER_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define GSM7PP_ASSERT_IMP(lbl, clk, rstn, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define GSM7PP_ASSERT_NXT(lbl, clk, rstn, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (cons)) else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define GSM7PP_ASSERT_NXT_ALWAYS(lbl, clk, ant, cons, msg) \
    lbl: assert property (@(posedge clk) (ant) |=> (cons)) else $error(msg);

`endif

// ----- sv/gsm7pp_pkg.sv -----
// Package of the GSM 7-bit page packer: payload types, codes and the alphabet map.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package gsm7pp_pkg;

    localparam int SEPTETS_PER_PAGE_DEF = 93;
    localparam int MAX_RESULTS          = 3;

    // Slot codes of the command field.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_PAD  = 1'b1;

    localparam logic [6:0] SEPT_CR = 7'h0d;
    localparam logic [6:0] SEPT_QM = 7'h3f;

    typedef struct packed {
        logic       command;
        logic [7:0] ascii_char;
    } gsm7pp_in_t;

    typedef struct packed {
        logic [7:0] page_octet;
        logic       is_count;
        logic       page_last;
    } gsm7pp_out_t;

    // All the results that one slot causes, in delivery order from index 0.
    typedef struct packed {
        logic [1:0]                    num;
        gsm7pp_out_t [MAX_RESULTS-1:0] res;
    } gsm7pp_bundle_t;

    // ASCII to GSM 7-bit default alphabet; anything without a code becomes '?'.
    function automatic logic [6:0] map_gsm7(input logic [7:0] ch);
        logic [6:0] sept;
        begin
            case (ch)
                8'h40: sept = 7'h00;
                8'h24: sept = 7'h02;
                8'h0a: sept = 7'h0a;
                8'h0d: sept = 7'h0d;
                8'h5f: sept = 7'h11;
                8'h5b: sept = 7'h3c;
                8'h5d: sept = 7'h3e;
                8'h7b: sept = 7'h28;
                8'h7d: sept = 7'h29;
                8'h5c: sept = 7'h2f;
                8'h7e: sept = 7'h3d;
                8'h7c: sept = 7'h40;
                8'h5e: sept = 7'h14;
                default: begin
                    if ((ch >= 8'h20 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a)) begin
                        sept = ch[6:0];
                    end else begin
                        sept = SEPT_QM;
                    end
                end
            endcase
            return sept;
        end
    endfunction

endpackage

// ----- sv/gsm7pp_packer.sv -----
// Septet packer of the GSM 7-bit page packer: maps one slot, packs it and builds its results.
// Depends on gsm7pp_pkg.
`timescale 1ns / 1ps

module gsm7pp_packer #(
    parameter int SEPTETS_PER_PAGE = gsm7pp_pkg::SEPTETS_PER_PAGE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  gsm7pp_pkg::gsm7pp_in_t     in_data,
    output logic                       push_valid,
    input  logic                       push_ready,
    output gsm7pp_pkg::gsm7pp_bundle_t push_data
);
    import gsm7pp_pkg::*;

    logic [13:0] bit_buffer_reg, bit_buffer_next;
    logic [2:0]  bit_fill_reg, bit_fill_next;
    logic [6:0]  slot_count_reg, slot_count_next;
    logic [6:0]  text_chars_reg, text_chars_next;
    logic        text_ended_reg, text_ended_next;

    logic        accept;
    logic        pad;
    logic [6:0]  sept;
    logic [13:0] buf_w;
    logic [3:0]  fill_w;
    logic [9:0]  count_w;
    logic [1:0]  num;
    gsm7pp_bundle_t bundle;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        pad  = text_ended_reg || (in_data.command == CMD_PAD) || (in_data.ascii_char == 8'h00);
        sept = pad ? SEPT_CR : map_gsm7(in_data.ascii_char);

        text_ended_next = text_ended_reg | pad;
        text_chars_next = pad ? text_chars_reg : text_chars_reg + 7'd1;

        buf_w  = bit_buffer_reg | (14'(sept) << bit_fill_reg);
        fill_w = {1'b0, bit_fill_reg} + 4'd7;
        bundle = '0;
        num    = 2'd0;

        // A whole octet is ready once eight or more bits are held.
        if (fill_w[3]) begin
            bundle.res[num] = '{page_octet: buf_w[7:0], is_count: 1'b0, page_last: 1'b0};
            num    = num + 2'd1;
            buf_w  = buf_w >> 8;
            fill_w = fill_w - 4'd8;
        end

        bit_buffer_next = buf_w;
        bit_fill_next   = fill_w[2:0];
        slot_count_next = slot_count_reg + 7'd1;

        // Used octets: ceil(chars * 7 / 8), with chars * 7 as (chars * 8 - chars).
        count_w = ({3'b0, text_chars_next} << 3) - {3'b0, text_chars_next} + 10'd7;

        if (slot_count_next >= 7'(SEPTETS_PER_PAGE)) begin
            if (fill_w != 4'd0) begin
                bundle.res[num] = '{page_octet: buf_w[7:0], is_count: 1'b0, page_last: 1'b0};
                num = num + 2'd1;
            end
            bundle.res[num] = '{page_octet: {1'b0, count_w[9:3]}, is_count: 1'b1,
                                page_last: 1'b1};
            num = num + 2'd1;
            bit_buffer_next = '0;
            bit_fill_next   = '0;
            slot_count_next = '0;
            text_chars_next = '0;
            text_ended_next = 1'b0;
        end
        bundle.num = num;
    end

    assign push_valid = accept && (num != 2'd0);
    assign push_data  = bundle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_buffer_reg <= '0;
            bit_fill_reg   <= '0;
            slot_count_reg <= '0;
            text_chars_reg <= '0;
            text_ended_reg <= 1'b0;
        end else if (accept) begin
            bit_buffer_reg <= bit_buffer_next;
            bit_fill_reg   <= bit_fill_next;
            slot_count_reg <= slot_count_next;
            text_chars_reg <= text_chars_next;
            text_ended_reg <= text_ended_next;
        end
    end

endmodule

// ----- sv/gsm7pp_outq.sv -----
// GSM 7-bit page packer result queue: holds two slot bundles, sends one octet a cycle while m_ready.
// Depends on gsm7pp_pkg.
`timescale 1ns / 1ps

module gsm7pp_outq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push_valid,
    output logic                       push_ready,
    input  gsm7pp_pkg::gsm7pp_bundle_t push_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output gsm7pp_pkg::gsm7pp_out_t    m_data
);
    import gsm7pp_pkg::*;

    gsm7pp_bundle_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic [1:0]     idx_reg, idx_next;

    gsm7pp_bundle_t head;
    logic           push;
    logic           pop;
    logic           head_done;

    assign head       = entry_reg[rd_ptr_reg];
    assign push_ready = (count_reg != 2'd2);
    assign push       = push_valid && push_ready;
    assign m_valid    = (count_reg != 2'd0);
    assign m_data     = head.res[idx_reg];
    assign head_done  = (idx_reg == head.num - 2'd1);
    assign pop        = m_valid && m_ready && head_done;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        idx_next    = idx_reg;
        if (m_valid && m_ready) begin
            idx_next = head_done ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
            idx_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

// ----- sv/gsm7_page_packer.sv -----
// GSM 7-bit page packer. Each input transfer is one septet slot of a broadcast page: a character
// is mapped to the GSM 7-bit default alphabet (anything without a code becomes '?'), while a pad
// slot, a NUL character and every slot after the first of these become CR and do not count as
// text. Septets are packed least significant bit first and each octet is sent as soon as it is
// complete. The last slot of the page flushes any partial octet, zero-filled above, and then
// sends the used-octet count ceil(chars * 7 / 8) with is_count and page_last set; the page then
// starts afresh. One slot is taken in every cycle while the result queue has room: the slot is
// mapped and packed in a single pass and its results land in a two-entry result queue, so the
// input keeps flowing while the result side stalls for up to two slots. The result port delivers
// one transfer per cycle while m_ready is high, and the page-end slot can cause three transfers.
// Depends on gsm7pp_pkg, gsm7pp_packer and gsm7pp_outq.
`timescale 1ns / 1ps

module gsm7_page_packer #(
    parameter int SEPTETS_PER_PAGE = gsm7pp_pkg::SEPTETS_PER_PAGE_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  gsm7pp_pkg::gsm7pp_in_t  s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output gsm7pp_pkg::gsm7pp_out_t m_data
);
    import gsm7pp_pkg::*;

    // Bundles of results travel from the packer to the queue, one per slot that causes any.
    logic           push_valid;
    logic           push_ready;
    gsm7pp_bundle_t push_data;

    // The packer keeps the page state and works out every result of an accepted slot.
    gsm7pp_packer #(
        .SEPTETS_PER_PAGE(SEPTETS_PER_PAGE)
    ) u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data)
    );

    // The queue parts the two sides and unrolls each bundle into single result transfers.
    gsm7pp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- sv/gsm7pp_checker.sv -----
// Port checker of the GSM 7-bit page packer and the bind that attaches it to the top level.
// Depends on gsm7pp_pkg and gsm7_page_packer_defines.svh.
`timescale 1ns / 1ps
`include "gsm7_page_packer_defines.svh"

module gsm7pp_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input gsm7pp_pkg::gsm7pp_in_t  s_data,
    input logic                    m_valid,
    input logic                    m_ready,
    input gsm7pp_pkg::gsm7pp_out_t m_data
);
    import gsm7pp_pkg::*;

    // A slot waiting on the block holds still.
    `GSM7PP_ASSERT_NXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data), "input changed while stalled")

    // A result waiting on the sink holds still.
    `GSM7PP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // The count byte is always the last octet of a page, and only it.
    `GSM7PP_ASSERT_IMP(a_count_last, aclk, aresetn, m_valid, m_data.is_count == m_data.page_last, "count and page end disagree")

    // The used-octet count never exceeds the octets a full page can hold.
    `GSM7PP_ASSERT_IMP(a_count_range, aclk, aresetn, m_valid && m_data.is_count, m_data.page_octet <= 8'd82, "used-octet count out of range")

    // Nothing is offered straight after reset.
    `GSM7PP_ASSERT_NXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid, "result offered after reset")

endmodule

bind gsm7_page_packer gsm7pp_checker u_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
